// ===== design/swl_pkg.sv =====
`default_nettype none

package swl_pkg;

  // Sequence index width; indices wrap modulo 2^SeqBits.
  localparam int SeqBits   = 16;
  localparam int IndexBits = 16;
  localparam int CountBits = 8;
  localparam int TickBits  = 16;

  typedef logic [SeqBits-1:0]   seq_t;
  typedef logic [IndexBits-1:0] index_t;
  typedef logic [CountBits-1:0] count_t;
  typedef logic [TickBits-1:0]  tick_t;

  typedef enum logic [1:0] {
    CmdSend = 2'd0,
    CmdRx   = 2'd1,
    CmdTick = 2'd2,
    CmdNone = 2'd3
  } cmd_e;

  // Received packet types; the other two codes are unknown types.
  localparam logic [1:0] PktAck = 2'd0;
  localparam logic [1:0] PktMsg = 2'd1;

  // Transmitted packet types.
  localparam logic TxAck = 1'b0;
  localparam logic TxMsg = 1'b1;

  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StBusy        = 3'd1,
    StAckIgnored  = 3'd2,
    StBadIndex    = 3'd3,
    StUnknownType = 3'd4,
    StGaveUp      = 3'd5,
    StHalted      = 3'd6
  } status_e;

  // Configuration register indexes.
  localparam logic CfgMaxSends   = 1'b0;
  localparam logic CfgRetryTicks = 1'b1;

  localparam count_t MaxSendsReset   = count_t'(5);
  localparam tick_t  RetryTicksReset = tick_t'(1000);

  typedef struct packed {
    cmd_e         command;
    logic [1:0]   rx_type;
    index_t       rx_index;
  } in_item_t;

  typedef struct packed {
    logic         tx_valid;
    logic         tx_type;
    index_t       tx_index;
    logic         deliver;
    status_e      status;
  } out_item_t;

endpackage

`default_nettype wire

// ===== design/swl_in_stage.sv =====
`default_nettype none

module swl_in_stage (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire swl_pkg::in_item_t  item_i,
  input  wire logic               advance_i,
  output logic                    valid_o,
  output swl_pkg::in_item_t       item_o
);
  import swl_pkg::*;

  logic     valid_q;
  in_item_t item_q;

  // Slot frees up whenever the engine consumes the held item.
  assign ready_o = !valid_q || advance_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== design/swl_engine.sv =====
`default_nettype none

module swl_engine (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_index_i,
  input  wire logic [15:0]        cfg_data_i,
  input  wire logic               fire_i,
  input  wire swl_pkg::in_item_t  item_i,
  output swl_pkg::out_item_t      result_o,
  output logic                    halted_o
);
  import swl_pkg::*;

  count_t max_sends_q;
  tick_t  retry_ticks_q;

  seq_t   sent_seq_q, sent_seq_d;
  seq_t   recv_seq_q, recv_seq_d;
  logic   awaiting_q, awaiting_d;
  count_t send_count_q, send_count_d;
  tick_t  wait_ticks_q, wait_ticks_d;
  logic   halted_q, halted_d;

  seq_t   rx_seq;
  seq_t   sent_next;
  seq_t   recv_next;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_sends_q   <= MaxSendsReset;
      retry_ticks_q <= RetryTicksReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgMaxSends:   max_sends_q   <= cfg_data_i[CountBits-1:0];
        CfgRetryTicks: retry_ticks_q <= cfg_data_i[TickBits-1:0];
        default: ;
      endcase
    end
  end

  assign rx_seq    = seq_t'(item_i.rx_index);
  assign sent_next = sent_seq_q + seq_t'(1);
  assign recv_next = recv_seq_q + seq_t'(1);

  always_comb begin
    sent_seq_d   = sent_seq_q;
    recv_seq_d   = recv_seq_q;
    awaiting_d   = awaiting_q;
    send_count_d = send_count_q;
    wait_ticks_d = wait_ticks_q;
    halted_d     = halted_q;
    result_o     = '0;
    result_o.status = StOk;

    if (halted_q) begin
      result_o.status = StHalted;
    end else begin
      case (item_i.command)
        CmdSend: begin
          if (awaiting_q) begin
            result_o.status = StBusy;
          end else begin
            sent_seq_d        = sent_next;
            awaiting_d        = 1'b1;
            send_count_d      = count_t'(1);
            wait_ticks_d      = retry_ticks_q;
            result_o.tx_valid = 1'b1;
            result_o.tx_type  = TxMsg;
            result_o.tx_index = index_t'(sent_next);
          end
        end
        CmdRx: begin
          case (item_i.rx_type)
            PktAck: begin
              if (awaiting_q && rx_seq == sent_seq_q) begin
                awaiting_d   = 1'b0;
                send_count_d = '0;
                wait_ticks_d = '0;
              end else begin
                result_o.status = StAckIgnored;
              end
            end
            PktMsg: begin
              if (rx_seq == recv_next) begin
                recv_seq_d        = rx_seq;
                result_o.tx_valid = 1'b1;
                result_o.tx_type  = TxAck;
                result_o.tx_index = index_t'(rx_seq);
                result_o.deliver  = 1'b1;
              end else if (rx_seq == recv_seq_q) begin
                // duplicate: acknowledge again, nothing goes upward
                result_o.tx_valid = 1'b1;
                result_o.tx_type  = TxAck;
                result_o.tx_index = index_t'(recv_seq_q);
              end else begin
                result_o.status = StBadIndex;
              end
            end
            default: begin
              halted_d        = 1'b1;
              result_o.status = StUnknownType;
            end
          endcase
        end
        CmdTick: begin
          if (awaiting_q) begin
            if (wait_ticks_q > tick_t'(1)) begin
              wait_ticks_d = wait_ticks_q - tick_t'(1);
            end else if (send_count_q >= max_sends_q) begin
              halted_d        = 1'b1;
              wait_ticks_d    = '0;
              result_o.status = StGaveUp;
            end else begin
              send_count_d      = send_count_q + count_t'(1);
              wait_ticks_d      = retry_ticks_q;
              result_o.tx_valid = 1'b1;
              result_o.tx_type  = TxMsg;
              result_o.tx_index = index_t'(sent_seq_q);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_seq_q   <= '0;
      recv_seq_q   <= '0;
      awaiting_q   <= 1'b0;
      send_count_q <= '0;
      wait_ticks_q <= '0;
      halted_q     <= 1'b0;
    end else if (fire_i) begin
      sent_seq_q   <= sent_seq_d;
      recv_seq_q   <= recv_seq_d;
      awaiting_q   <= awaiting_d;
      send_count_q <= send_count_d;
      wait_ticks_q <= wait_ticks_d;
      halted_q     <= halted_d;
    end
  end

  assign halted_o = halted_q;

endmodule

`default_nettype wire

// ===== design/swl_out_stage.sv =====
`default_nettype none

module swl_out_stage (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire swl_pkg::out_item_t  item_i,
  output logic                     free_o,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output swl_pkg::out_item_t       item_o
);
  import swl_pkg::*;

  logic      valid_q;
  out_item_t item_q;

  assign free_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && free_o) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

// ===== design/stop_and_wait_link_top.sv =====
`default_nettype none

// Stop-and-wait link endpoint. Each input transfer is a send request, a received
// packet header or a timer tick; each one yields exactly one result transfer that
// carries the header to transmit (if any), a deliver flag and a status code.
// Items pass through an input register, combinational decision logic against the
// link state, and an output register. With the output side ready, one item is
// taken per clock; its result passes the decision logic into the output register
// and is offered there. While a result waits on the output, the input register
// takes at most one more item, and then the input stalls until the result is taken.
// Configuration (max_sends at index 0, retry_ticks at index 1) is always ready
// and should be written only while no item is in flight. After a give-up or an
// unknown packet type the block answers every item with status halted until reset.
module stop_and_wait_link_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_tvalid_i,
  output logic             s_tready_o,
  input  wire logic [15:0] s_tdata_i,   // [15:0] rx_index
  input  wire logic [3:0]  s_tuser_i,   // [1:0] command, [3:2] rx_type
  output logic             m_tvalid_o,
  input  wire logic        m_tready_i,
  output logic [23:0]      m_tdata_o,   // [15:0] tx_index, [18:16] status, [23:19] zero
  output logic [2:0]       m_tuser_o,   // [0] tx_valid, [1] tx_type, [2] deliver
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [15:0] cfg_data_i
);
  import swl_pkg::*;

  in_item_t  s_item;
  in_item_t  held_item;
  logic      held_valid;
  logic      out_free;
  logic      eng_fire;
  out_item_t eng_result;
  out_item_t m_item;
  logic      halted;

  assign s_item.command  = cmd_e'(s_tuser_i[1:0]);
  assign s_item.rx_type  = s_tuser_i[3:2];
  assign s_item.rx_index = s_tdata_i;

  assign eng_fire    = held_valid && out_free;
  assign cfg_ready_o = 1'b1;

  swl_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s_tvalid_i),
    .ready_o   (s_tready_o),
    .item_i    (s_item),
    .advance_i (out_free),
    .valid_o   (held_valid),
    .item_o    (held_item)
  );

  swl_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fire_i      (eng_fire),
    .item_i      (held_item),
    .result_o    (eng_result),
    .halted_o    (halted)
  );

  swl_out_stage u_out_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (eng_fire),
    .item_i  (eng_result),
    .free_o  (out_free),
    .valid_o (m_tvalid_o),
    .ready_i (m_tready_i),
    .item_o  (m_item)
  );

  assign m_tdata_o = {5'b0, m_item.status, m_item.tx_index};
  assign m_tuser_o = {m_item.deliver, m_item.tx_type, m_item.tx_valid};

`ifndef SYNTHESIS
  // Only a new in-order MSG is delivered, and it is always acknowledged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_fire && eng_result.deliver |-> eng_result.tx_valid && eng_result.tx_type == TxAck)
    else $error("deliver without matching ACK");

  // A transmitted header never comes with an error status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_fire && eng_result.tx_valid |-> eng_result.status == StOk)
    else $error("header sent with error status");

  // Give-up and unknown type both latch the halt.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_fire && (eng_result.status == StGaveUp || eng_result.status == StUnknownType)
    |=> halted)
    else $error("halt not latched");

  // Once halted, the engine only reports halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    eng_fire && halted |-> eng_result.status == StHalted && !eng_result.tx_valid)
    else $error("activity while halted");
`endif

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swl_pkg::*;

  localparam logic [1:0] PktOddLo = 2'd2;  // unknown packet types
  localparam logic [1:0] PktOddHi = 2'd3;
  localparam int unsigned RunLimitNs = 10_000_000;
  localparam int unsigned NumPhases = 10;
  localparam int unsigned PhaseItems = 165;

  typedef struct {
    count_t max_sends;
    tick_t  retry_ticks;
    seq_t   sent_seq;
    seq_t   acked_seq;
    seq_t   recv_seq;
    logic   awaiting;
    count_t send_count;
    tick_t  wait_ticks;
    logic   halted;
  } link_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [15:0] s_tdata_i = '0;   // [15:0] rx_index
  logic [3:0]  s_tuser_i = '0;   // [1:0] command, [3:2] rx_type
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [23:0] m_tdata_o;        // [15:0] tx_index, [18:16] status, [23:19] zero
  logic [2:0]  m_tuser_o;        // [0] tx_valid, [1] tx_type, [2] deliver
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CfgMaxSends;
  logic [15:0] cfg_data_i = '0;

  stop_and_wait_link_top i_dut (.*);

  in_item_t    pending_items[$];
  out_item_t   due_results[$];
  link_state_t link_now;   // advanced on accepted transfers
  link_state_t link_plan;  // advanced as items are generated
  int unsigned fail_count = 0;
  int unsigned checked = 0;
  int unsigned msgs_out = 0;
  int unsigned acks_out = 0;
  int unsigned delivered = 0;
  int unsigned status_tally[8];
  bit          by_giveup;

  initial forever #10 clk_i = ~clk_i;

  initial begin
    #(RunLimitNs);
    $display("FAIL");
    $finish;
  end

  function automatic link_state_t fresh_state();
    link_state_t s;
    s.max_sends = MaxSendsReset;
    s.retry_ticks = RetryTicksReset;
    s.sent_seq = '0;
    s.acked_seq = '0;
    s.recv_seq = '0;
    s.awaiting = 1'b0;
    s.send_count = '0;
    s.wait_ticks = '0;
    s.halted = 1'b0;
    return s;
  endfunction

  function automatic void set_reg(inout link_state_t s, input logic idx, input logic [15:0] val);
    if (idx == CfgMaxSends) s.max_sends = val[7:0];
    else s.retry_ticks = val;
  endfunction

  // One item through the link endpoint; returns the single result it causes.
  function automatic out_item_t link_step(inout link_state_t s, input in_item_t it);
    out_item_t r;
    seq_t idx;
    seq_t next_seq;
    r = '0;
    r.status = StOk;
    idx = seq_t'(it.rx_index);
    next_seq = s.recv_seq + 1'b1;
    if (s.halted) begin
      r.status = StHalted;
      return r;
    end
    case (it.command)
      CmdSend: begin
        if (s.awaiting) begin
          r.status = StBusy;
        end else begin
          s.sent_seq = s.sent_seq + 1'b1;
          s.awaiting = 1'b1;
          s.send_count = count_t'(1);
          s.wait_ticks = s.retry_ticks;
          r.tx_valid = 1'b1;
          r.tx_type = TxMsg;
          r.tx_index = index_t'(s.sent_seq);
        end
      end
      CmdRx: begin
        if (it.rx_type == PktAck) begin
          if (s.awaiting && idx == s.sent_seq) begin
            s.acked_seq = s.sent_seq;
            s.awaiting = 1'b0;
            s.send_count = '0;
            s.wait_ticks = '0;
          end else begin
            r.status = StAckIgnored;
          end
        end else if (it.rx_type == PktMsg) begin
          if (idx == next_seq) begin
            s.recv_seq = idx;
            r.tx_valid = 1'b1;
            r.tx_type = TxAck;
            r.tx_index = index_t'(idx);
            r.deliver = 1'b1;
          end else if (idx == s.recv_seq) begin
            r.tx_valid = 1'b1;
            r.tx_type = TxAck;
            r.tx_index = index_t'(idx);
          end else begin
            r.status = StBadIndex;
          end
        end else begin
          s.halted = 1'b1;
          r.status = StUnknownType;
        end
      end
      CmdTick: begin
        if (s.awaiting) begin
          if (s.wait_ticks > 1) begin
            s.wait_ticks = s.wait_ticks - 1'b1;
          end else if (s.send_count >= s.max_sends) begin
            s.halted = 1'b1;
            s.wait_ticks = '0;
            r.status = StGaveUp;
          end else begin
            s.send_count = s.send_count + 1'b1;
            s.wait_ticks = s.retry_ticks;
            r.tx_valid = 1'b1;
            r.tx_type = TxMsg;
            r.tx_index = index_t'(s.sent_seq);
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk(cmd_e c, logic [1:0] t, index_t i);
    in_item_t it;
    it.command = c;
    it.rx_type = t;
    it.rx_index = i;
    return it;
  endfunction

  // Mostly protocol-correct traffic that never halts the endpoint.
  function automatic in_item_t pick_item(link_state_t s);
    in_item_t it;
    int unsigned roll;
    seq_t next_seq;
    next_seq = s.recv_seq + 1'b1;
    roll = $urandom_range(0, 99);
    it = mk(CmdRx, PktMsg, 16'($urandom));
    if (roll < 20) begin
      it.command = CmdSend;
      it.rx_type = 2'($urandom);
    end else if (roll < 42) begin
      it.command = CmdTick;
      it.rx_type = 2'($urandom);
    end else if (roll < 58) begin
      it.rx_type = PktAck;
      it.rx_index = index_t'(s.sent_seq);
    end else if (roll < 72) begin
      it.rx_index = index_t'(next_seq);
    end else if (roll < 80) begin
      it.rx_index = index_t'(s.recv_seq);
    end else if (roll < 86) begin
      it.rx_index = $urandom_range(0, 1) ? index_t'(s.recv_seq + 2'd2)
                                         : index_t'(s.recv_seq - 1'b1);
    end else if (roll < 91) begin
      // random index, usually bad
    end else if (roll < 96) begin
      it.rx_type = PktAck;
    end else begin
      it.command = CmdNone;
      it.rx_type = 2'($urandom);
    end
    // a tick that would give up is turned into the matching ACK
    if (it.command == CmdTick && s.awaiting && s.wait_ticks <= 1 &&
        s.send_count >= s.max_sends) begin
      it = mk(CmdRx, PktAck, index_t'(s.sent_seq));
    end
    return it;
  endfunction

  task automatic queue_item(in_item_t it);
    void'(link_step(link_plan, it));
    pending_items.push_back(it);
  endtask

  // sampled at the falling edge so that the driver's updates have settled
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || s_tvalid_i || due_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    set_reg(link_now, idx, val);
    set_reg(link_plan, idx, val);
  endtask

  // Sender: bursts of random length separated by random gaps.
  in_item_t    on_bus;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid_i <= 1'b0;
    end else begin
      logic nv;
      nv = s_tvalid_i;
      if (s_tvalid_i && s_tready_o) begin
        due_results.push_back(link_step(link_now, on_bus));
        nv = 1'b0;
      end
      if (!(s_tvalid_i && !s_tready_o)) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (pending_items.size() != 0) begin
          on_bus = pending_items.pop_front();
          s_tdata_i <= on_bus.rx_index;
          s_tuser_i <= {on_bus.rx_type, on_bus.command};
          nv = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
      s_tvalid_i <= nv;
    end
  end

  // Receiver: picks a new stall mode whenever its stall counter runs out.
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else begin
      logic rdy;
      out_item_t got;
      out_item_t want;
      if (m_tvalid_o && m_tready_i) begin
        got = '0;
        got.tx_index = m_tdata_o[15:0];
        got.status   = status_e'(m_tdata_o[18:16]);
        got.tx_valid = m_tuser_o[0];
        got.tx_type  = m_tuser_o[1];
        got.deliver  = m_tuser_o[2];
        checked++;
        status_tally[m_tdata_o[18:16]]++;
        if (got.tx_valid && got.tx_type == TxMsg) msgs_out++;
        if (got.tx_valid && got.tx_type == TxAck) acks_out++;
        if (got.deliver) delivered++;
        if (due_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("error: unexpected result transfer %0d, status %0d", checked,
                     m_tdata_o[18:16]);
        end else begin
          want = due_results.pop_front();
          if (got.tx_valid !== want.tx_valid || got.tx_type !== want.tx_type ||
              got.tx_index !== want.tx_index || got.deliver !== want.deliver ||
              got.status !== want.status || m_tdata_o[23:19] !== 5'd0) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"error: result %0d valid/type/index/deliver/status/pad ",
                        "want %0b/%0b/%h/%0b/%0d/0 got %0b/%0b/%h/%0b/%0d/%h"},
                       checked, want.tx_valid, want.tx_type, want.tx_index,
                       want.deliver, want.status, got.tx_valid, got.tx_type,
                       got.tx_index, got.deliver, m_tdata_o[18:16], m_tdata_o[23:19]);
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(16, 64);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: rdy = 1'b1;
        1: rdy = 1'($urandom_range(0, 1));
        default: rdy = ($urandom_range(0, 7) == 0);
      endcase
      m_tready_i <= rdy;
    end
  end

  localparam int unsigned MaxSendsTab[6]   = '{3, 1, 0, 255, 2, 4};
  localparam int unsigned RetryTicksTab[6] = '{2, 1, 0, 3, 65535, 0};

  initial begin
    int unsigned ms;
    int unsigned rt;
    link_now = fresh_state();
    link_plan = fresh_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // idle behavior, duplicates, bad indexes and ignored ACKs at reset config
    queue_item(mk(CmdTick, PktAck, 16'h0000));
    queue_item(mk(CmdNone, PktOddHi, 16'hFFFF));
    queue_item(mk(CmdRx, PktAck, 16'h0000));
    queue_item(mk(CmdRx, PktMsg, 16'h0000));
    queue_item(mk(CmdRx, PktMsg, 16'h0001));
    queue_item(mk(CmdRx, PktMsg, 16'hFFFF));
    queue_item(mk(CmdRx, PktMsg, 16'h0000));
    queue_item(mk(CmdRx, PktMsg, 16'h0001));
    queue_item(mk(CmdSend, PktOddLo, 16'hFFFF));
    queue_item(mk(CmdSend, PktMsg, 16'h0000));
    queue_item(mk(CmdRx, PktAck, 16'hFFFF));
    queue_item(mk(CmdRx, PktAck, 16'h0000));
    queue_item(mk(CmdTick, PktOddHi, 16'h5555));
    queue_item(mk(CmdRx, PktAck, 16'h0001));
    queue_item(mk(CmdRx, PktAck, 16'h0001));
    queue_item(mk(CmdRx, PktMsg, 16'h0002));
    queue_item(mk(CmdTick, PktMsg, 16'hAAAA));
    queue_item(mk(CmdSend, PktAck, 16'h0000));
    queue_item(mk(CmdRx, PktMsg, 16'h8000));
    queue_item(mk(CmdRx, PktAck, 16'h0002));
    wait_idle();

    // one retransmission on timeout
    write_reg(CfgMaxSends, 16'h0002);
    write_reg(CfgRetryTicks, 16'h0001);
    queue_item(mk(CmdSend, PktAck, 16'h0000));
    queue_item(mk(CmdTick, PktAck, 16'h0000));
    queue_item(mk(CmdRx, PktAck, 16'h0003));

    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      if (p < 6) begin
        ms = MaxSendsTab[p];
        rt = RetryTicksTab[p];
      end else begin
        ms = $urandom_range(1, 6);
        rt = $urandom_range(1, 12);
      end
      write_reg(CfgMaxSends, {8'($urandom), 8'(ms)});
      write_reg(CfgRetryTicks, 16'(rt));
      repeat (PhaseItems) queue_item(pick_item(link_plan));
    end

    // the endpoint halts once, by give-up or by an unknown type
    wait_idle();
    by_giveup = 1'($urandom_range(0, 1));
    if (by_giveup) begin
      write_reg(CfgMaxSends, 16'($urandom_range(1, 2)));
      write_reg(CfgRetryTicks, 16'($urandom_range(0, 2)));
      while (!link_plan.halted) begin
        if (link_plan.awaiting && link_plan.wait_ticks > 4)
          queue_item(mk(CmdRx, PktAck, index_t'(link_plan.sent_seq)));
        else if (link_plan.awaiting)
          queue_item(mk(CmdTick, 2'($urandom), 16'($urandom)));
        else
          queue_item(mk(CmdSend, 2'($urandom), 16'($urandom)));
      end
    end else begin
      queue_item(mk(CmdRx, $urandom_range(0, 1) ? PktOddLo : PktOddHi, 16'($urandom)));
    end
    repeat (40) queue_item(mk(cmd_e'($urandom_range(0, 3)), 2'($urandom), 16'($urandom)));
    wait_idle();
    // registers stay writable while halted
    write_reg(CfgMaxSends, 16'h00FF);
    write_reg(CfgRetryTicks, 16'hFFFF);
    repeat (10) queue_item(pick_item(link_plan));
    wait_idle();

    $display("%0d results checked: %0d MSG and %0d ACK headers sent, %0d deliveries",
             checked, msgs_out, acks_out, delivered);
    $display({"status ok/busy/ack-ignored/bad-index/unknown/gave-up/halted ",
              "%0d/%0d/%0d/%0d/%0d/%0d/%0d, halted by %s"},
             status_tally[StOk], status_tally[StBusy], status_tally[StAckIgnored],
             status_tally[StBadIndex], status_tally[StUnknownType],
             status_tally[StGaveUp], status_tally[StHalted],
             by_giveup ? "give-up" : "unknown type");
    if (fail_count == 0 && due_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
design/swl_pkg.sv
design/swl_in_stage.sv
design/swl_engine.sv
design/swl_out_stage.sv
design/stop_and_wait_link_top.sv
test/tb.sv
